### src/voxel_point_lookup_macros.svh
// Assertion helpers for the voxel point lookup
`ifndef VOXEL_POINT_LOOKUP_MACROS_SVH
`define VOXEL_POINT_LOOKUP_MACROS_SVH

// same-cycle implication
`define VPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vpl_pkg.sv
// ----------------------------------------------------------------------------
// vpl_pkg
// Shared types and constants of the voxel point lookup.
// ----------------------------------------------------------------------------
package vpl_pkg;

    localparam int STORE_DEPTH_DEF    = 65536;
    localparam int MATERIAL_LIMIT_DEF = 64;

    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 9;
    localparam int PART_W    = 18;
    localparam int FLAT_W    = 27;
    localparam int N_STAGES  = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_CELL_SIZE = 3'd3,
        CFG_COUNT_X   = 3'd4,
        CFG_COUNT_Y   = 3'd5,
        CFG_COUNT_Z   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                   vld;
        logic                   kind;
        logic                   ok;
        logic                   last;
        logic [5:0]             mat;
        logic [15:0]            vol;
        logic [2:0][32:0]       rem;
        logic [2:0][CNT_W-1:0]  quo;
        logic [PART_W-1:0]      part;
        logic [FLAT_W-1:0]      flat;
    } t_stage;

endpackage

### src/voxel_point_lookup.sv
// An accepted word passes through stages 0 to 12 and then the output register.
// Throughput: one word per cycle when no stall holds; the divider runs one quotient bit per stage.
// Stalls hold each stage in place; empty stages fill while the output waits.
// Reset clears all valid bits and the built flag and sets the configuration registers to defaults.
// The voxel stores are not cleared by reset.
// ----------------------------------------------------------------------------
// voxel_point_lookup
// Uniform voxel grid: loads fill the stores, queries return the voxel ids.
// ----------------------------------------------------------------------------
module voxel_point_lookup #(
    parameter int STORE_DEPTH    = vpl_pkg::STORE_DEPTH_DEF,
    parameter int MATERIAL_LIMIT = vpl_pkg::MATERIAL_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vpl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [15:0]                   i_load_index,
    input  logic [5:0]                    i_load_material,
    input  logic [15:0]                   i_load_volume,
    input  logic                          i_load_last,
    input  logic signed [31:0]            i_point_x,
    input  logic signed [31:0]            i_point_y,
    input  logic signed [31:0]            i_point_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [5:0]                    o_material_id,
    output logic [15:0]                   o_volume_id
);
    import vpl_pkg::*;
    `include "voxel_point_lookup_macros.svh"

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NS = N_STAGES;

    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic [30:0]        r_cell;
    logic [CNT_W-1:0]   r_cnt_x, r_cnt_y, r_cnt_z;
    logic               r_built;

    t_stage r_st [NS];
    t_stage n_st [NS];
    logic [NS:0] en;

    logic        r_o_vld;
    logic        r_found;
    logic [5:0]  r_mat;
    logic [15:0] r_vol;

    logic [5:0]  mem_mat [STORE_DEPTH];
    logic [15:0] mem_vol [STORE_DEPTH];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_cell  <= 31'd65536;
            r_cnt_x <= CNT_W'(1);
            r_cnt_y <= CNT_W'(1);
            r_cnt_z <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:  r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y:  r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z:  r_org_z <= i_cfg_data;
                CFG_CELL_SIZE: r_cell  <= i_cfg_data[30:0];
                CFG_COUNT_X:   r_cnt_x <= i_cfg_data[CNT_W-1:0];
                CFG_COUNT_Y:   r_cnt_y <= i_cfg_data[CNT_W-1:0];
                CFG_COUNT_Z:   r_cnt_z <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stall chain
    always_comb begin
        en[NS] = !r_o_vld || i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_st[k].vld || en[k+1];
        end
    end
    assign o_ready = en[0];

    // stage 0: capture, origin subtract, load checks
    always_comb begin
        n_st[0]      = '0;
        n_st[0].vld  = i_valid;
        n_st[0].kind = i_kind;
        n_st[0].last = i_load_last;
        n_st[0].mat  = i_load_material;
        n_st[0].vol  = i_load_volume;
        n_st[0].flat = FLAT_W'(i_load_index);
        n_st[0].ok   = i_kind ||
                       (({16'd0, i_load_index} < 32'(STORE_DEPTH)) &&
                        ({26'd0, i_load_material} < 32'(MATERIAL_LIMIT)));
        n_st[0].rem[0] = 33'({i_point_x[31], i_point_x} - {r_org_x[31], r_org_x});
        n_st[0].rem[1] = 33'({i_point_y[31], i_point_y} - {r_org_y[31], r_org_y});
        n_st[0].rem[2] = 33'({i_point_z[31], i_point_z} - {r_org_z[31], r_org_z});
    end

    // stage 1: sign, zero size and quotient overflow
    always_comb begin
        n_st[1] = r_st[0];
        if (r_st[0].kind) begin
            n_st[1].ok = (r_cell != '0);
            for (int a = 0; a < 3; a++) begin
                if (r_st[0].rem[a][32] ||
                    ({7'd0, r_st[0].rem[a]} >= {r_cell, 9'd0})) begin
                    n_st[1].ok = 1'b0;
                end
            end
        end
    end

    // stages 2..10: restoring divide, one quotient bit each
    for (genvar k = 2; k <= 10; k++) begin : g_div
        localparam int B = 10 - k;
        always_comb begin
            logic [39:0] sh;
            logic [39:0] rw;
            n_st[k] = r_st[k-1];
            sh = {9'd0, r_cell} << B;
            for (int a = 0; a < 3; a++) begin
                rw = {7'd0, r_st[k-1].rem[a]};
                if (rw >= sh) begin
                    n_st[k].rem[a]    = 33'(rw - sh);
                    n_st[k].quo[a][B] = 1'b1;
                end else begin
                    n_st[k].quo[a][B] = 1'b0;
                end
            end
        end
    end

    // stage 11: range checks and first product
    always_comb begin
        n_st[11] = r_st[10];
        if (r_st[10].kind) begin
            n_st[11].ok = r_st[10].ok &&
                          (r_st[10].quo[0] < r_cnt_x) &&
                          (r_st[10].quo[1] < r_cnt_y) &&
                          (r_st[10].quo[2] < r_cnt_z);
        end
        n_st[11].part = PART_W'(r_st[10].quo[2]) * PART_W'(r_cnt_y) +
                        PART_W'(r_st[10].quo[1]);
    end

    // stage 12: flat index
    always_comb begin
        n_st[12] = r_st[11];
        if (r_st[11].kind) begin
            n_st[12].flat = FLAT_W'(r_st[11].part) * FLAT_W'(r_cnt_x) +
                            FLAT_W'(r_st[11].quo[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (!i_rst_n) begin
                r_st[k].vld <= 1'b0;
            end else if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // store access and output word
    logic          s_in_range;
    logic [AW-1:0] s_addr;
    assign s_in_range = ({5'd0, r_st[12].flat} < 32'(STORE_DEPTH));
    assign s_addr     = r_st[12].flat[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            if (r_st[12].vld && !r_st[12].kind && r_st[12].ok) begin
                mem_mat[s_addr] <= r_st[12].mat;
                mem_vol[s_addr] <= r_st[12].vol;
            end
            r_mat <= mem_mat[s_addr];
            r_vol <= mem_vol[s_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_found <= 1'b0;
            r_built <= 1'b0;
        end else if (en[NS]) begin
            r_o_vld <= r_st[12].vld && r_st[12].kind;
            r_found <= r_st[12].ok && r_built && s_in_range;
            if (r_st[12].vld && !r_st[12].kind && r_st[12].last) begin
                r_built <= 1'b1;
            end
        end
    end

    assign o_valid       = r_o_vld;
    assign o_found       = r_found;
    assign o_material_id = r_found ? r_mat : 6'd0;
    assign o_volume_id   = r_found ? r_vol : 16'd0;

    `VPL_ASSERT_IMPL(a_found_built, r_o_vld && r_found, r_built, "found before grid built")
    `VPL_ASSERT_NEXT(a_load_silent, r_st[12].vld && !r_st[12].kind && en[NS], !r_o_vld, "load produced a word")
    `VPL_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, r_st[0].vld, "accepted word lost at entry")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the voxel point lookup: a short directed table run under the
// reset grid, then grid phases with random loads and queries, each result
// checked against its table row or a local copy of stores and grid settings.
// ----------------------------------------------------------------------------
module tb;
    import vpl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit        found;
        bit [5:0]  mat;
        bit [15:0] vol;
    } t_hit;

    typedef struct {
        bit        kind;
        bit [15:0] idx;
        bit [5:0]  mat;
        bit [15:0] vol;
        bit        last;
        bit [31:0] px, py, pz;
        bit        typed;
        t_hit      res;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid, o_ready;
    logic        i_kind, i_load_last;
    logic [15:0] i_load_index, i_load_volume;
    logic [5:0]  i_load_material;
    logic signed [31:0] i_point_x, i_point_y, i_point_z;
    logic        o_valid, i_ready, o_found;
    logic [5:0]  o_material_id;
    logic [15:0] o_volume_id;

    voxel_point_lookup uut (.*);

    // local grid copy
    bit [5:0]  mat_mem [STORE_DEPTH_DEF];
    bit [15:0] vol_mem [STORE_DEPTH_DEF];
    bit        written [STORE_DEPTH_DEF];
    bit        built;
    longint    org [3];
    longint    vox_size;
    longint    cnt [3];

    t_hit hit_q[$];
    int   errors, n_words, n_hits, n_miss, cycles;
    bit   tx_burst, rx_burst;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side stalls
    int rx_wait;
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_ready <= 0;
            rx_wait <= 0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            i_ready <= (rx_wait == 1);
        end else if (o_valid && i_ready) begin
            w = rx_burst ? 0 : $urandom_range(0, 10);
            rx_wait <= w;
            i_ready <= (w == 0);
        end else begin
            i_ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected word found=%0d mat=%0d vol=%0d",
                         $realtime, o_found, o_material_id, o_volume_id);
                errors++;
            end else begin
                e = hit_q.pop_front();
                if (o_found !== e.found || o_material_id !== e.mat
                        || o_volume_id !== e.vol) begin
                    $display("%0t: expected found=%0d mat=%0d vol=%0d, got %0d %0d %0d",
                             $realtime, e.found, e.mat, e.vol,
                             o_found, o_material_id, o_volume_id);
                    errors++;
                end
                if (e.found) n_hits++; else n_miss++;
            end
        end
    end

    function automatic bit cell_index(bit [31:0] p, int a, output longint q);
        longint d;
        d = longint'($signed(p)) - org[a];
        if (d < 0 || vox_size == 0) return 0;
        q = d / vox_size;
        return q < cnt[a];
    endfunction

    function automatic t_hit lookup_voxel(bit [31:0] px, py, pz, output longint flat);
        t_hit r;
        longint ix, iy, iz;
        r = '{0, 0, 0};
        flat = -1;
        if (!built || !cell_index(px, 0, ix) || !cell_index(py, 1, iy)
                || !cell_index(pz, 2, iz)) return r;
        flat = (iz * cnt[1] + iy) * cnt[0] + ix;
        if (flat >= STORE_DEPTH_DEF) begin
            flat = -1;
            return r;
        end
        r = '{1, mat_mem[flat], vol_mem[flat]};
        return r;
    endfunction

    // leaves valid high on return so back-to-back words need no drop
    task automatic send_word(t_row w);
        int gap;
        longint flat;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1;
        i_kind          <= w.kind;
        i_load_index    <= w.idx;
        i_load_material <= w.mat;
        i_load_volume   <= w.vol;
        i_load_last     <= w.last;
        i_point_x       <= w.px;
        i_point_y       <= w.py;
        i_point_z       <= w.pz;
        if (w.kind == 0) begin
            mat_mem[w.idx] = w.mat;
            vol_mem[w.idx] = w.vol;
            written[w.idx] = 1;
            if (w.last) built = 1;
        end else if (w.typed) begin
            hit_q = {hit_q, w.res};
        end else begin
            hit_q = {hit_q, lookup_voxel(w.px, w.py, w.pz, flat)};
        end
        n_words++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_grid(longint ox, oy, oz, cs, cx, cy, cz);
        bit [31:0] v [7];
        v = '{ox[31:0], oy[31:0], oz[31:0], cs[31:0], cx[31:0], cy[31:0], cz[31:0]};
        for (int i = 0; i < 7; i++) begin
            i_cfg_wr_en <= 1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= v[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 0;
        org[0] = $signed(v[CFG_ORIGIN_X]);
        org[1] = $signed(v[CFG_ORIGIN_Y]);
        org[2] = $signed(v[CFG_ORIGIN_Z]);
        vox_size = v[CFG_CELL_SIZE] & 32'h7FFF_FFFF;
        cnt[0] = v[CFG_COUNT_X] & 9'h1FF;
        cnt[1] = v[CFG_COUNT_Y] & 9'h1FF;
        cnt[2] = v[CFG_COUNT_Z] & 9'h1FF;
        @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_coord(int a);
        longint p;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            p = org[a] + (cnt[a] > 0 ? longint'($urandom_range(0, cnt[a] - 1)) : 0) * vox_size
                + (vox_size > 0 ? longint'($urandom) % vox_size : 0);
        end else if (sel == 7) begin
            p = org[a] - 1;
        end else if (sel == 8) begin
            p = org[a] + cnt[a] * vox_size;
        end else begin
            p = $signed($urandom);
        end
        if (p > 64'sh7FFF_FFFF || p < -64'sh8000_0000) p = $signed($urandom);
        return p[31:0];
    endfunction

    task automatic random_phase(int n);
        t_row w;
        longint flat;
        t_hit h;
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            w = '{default: 0};
            w.idx  = 16'($urandom);
            w.mat  = 6'($urandom);
            w.vol  = 16'($urandom);
            w.last = ($urandom_range(0, 7) == 0);
            w.px   = $urandom;
            w.py   = $urandom;
            w.pz   = $urandom;
            if ($urandom_range(0, 3) != 0) begin
                w.kind = 1;
                w.px = pick_coord(0);
                w.py = pick_coord(1);
                w.pz = pick_coord(2);
                h = lookup_voxel(w.px, w.py, w.pz, flat);
                // never read a voxel that was not loaded
                if (h.found && !written[flat]) begin
                    t_row ld;
                    ld = '{default: 0};
                    ld.idx = flat[15:0];
                    ld.mat = 6'($urandom);
                    ld.vol = 16'($urandom);
                    send_word(ld);
                end
            end
            send_word(w);
        end
        drain();
    endtask

    t_row dir_rows [15] = '{
        '{1, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, '{0, 0, 0}},
        '{0, 16'hFFFF, 6'd63, 16'hFFFF, 0, 0, 0, 0, 0, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, '{0, 0, 0}},
        '{0, 16'h0, 6'd5, 16'h1234, 1, 0, 0, 0, 0, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, '{1, 5, 16'h1234}},
        '{1, 0, 0, 0, 0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1, '{1, 5, 16'h1234}},
        '{1, 0, 0, 0, 0, 32'h1_0000, 32'h0, 32'h0, 1, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, '{0, 0, 0}},
        '{0, 16'h0, 6'd63, 16'hFFFF, 0, 0, 0, 0, 0, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, '{1, 63, 16'hFFFF}},
        '{0, 16'h0, 6'd0, 16'h0, 1, 0, 0, 0, 0, '{0, 0, 0}},
        '{1, 0, 0, 0, 0, 32'h0, 32'h0, 32'hFFFF, 1, '{1, 0, 0}}
    };

    initial begin
        i_rst_n = 0; i_cfg_wr_en = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_valid = 0; i_kind = 0; i_load_index = 0; i_load_material = 0;
        i_load_volume = 0; i_load_last = 0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0;
        errors = 0; n_words = 0; n_hits = 0; n_miss = 0; cycles = 0;
        built = 0; vox_size = 65536;
        org = '{0, 0, 0};
        cnt = '{1, 1, 1};
        tx_burst = 0; rx_burst = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_word(dir_rows[i]);
        drain();

        set_grid(0, 0, 0, 65536, 16, 16, 16);
        random_phase(110);
        set_grid(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 64'h7FFF_FFFF, 2, 2, 2);
        random_phase(90);
        set_grid(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 1, 1, 1, 1);
        random_phase(60);
        set_grid($signed($urandom_range(0, 4000)) - 2000, -300, 0, 1, 256, 256, 1);
        random_phase(130);
        set_grid(0, 0, 0, 32'h1000, 256, 256, 256);
        random_phase(100);
        set_grid(0, 0, 0, 65536, 0, 4, 0);
        random_phase(40);
        set_grid($signed($urandom), $signed($urandom), $signed($urandom),
                 $urandom_range(1, 1 << 20), $urandom_range(1, 40),
                 $urandom_range(1, 40), $urandom_range(1, 40));
        random_phase(130);

        $display("%0d words sent over seven grid settings", n_words);
        $display("%0d queries found a voxel, %0d missed", n_hits, n_miss);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
